@@ rtl/per_die_lru_page_buffer_assert.svh @@
// Assertion macros for the per-die LRU page buffer checker
`ifndef PER_DIE_LRU_PAGE_BUFFER_ASSERT_SVH
`define PER_DIE_LRU_PAGE_BUFFER_ASSERT_SVH

// same-cycle implication
`define PDLRU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("pdlru assertion failed");

// next-cycle implication
`define PDLRU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("pdlru assertion failed");

`endif

@@ rtl/pdlru_pkg.sv @@
// Types and constants shared by the per-die LRU page buffer modules
package pdlru_pkg;

	localparam int DIE_COUNT        = 32;
	localparam int CHANNEL_COUNT    = 8;
	localparam int ENTRIES_PER_DIE  = 16;
	localparam int SECTORS_PER_PAGE = 4;
	localparam int TOTAL_ENTRIES    = DIE_COUNT * ENTRIES_PER_DIE;
	localparam int ENT_W            = $clog2(TOTAL_ENTRIES);
	localparam int LINK_W           = ENT_W + 1;
	localparam int DIE_W            = $clog2(DIE_COUNT);
	localparam int EPD_W            = $clog2(ENTRIES_PER_DIE);
	localparam int SPP_W            = $clog2(SECTORS_PER_PAGE);
	localparam int CH_W             = $clog2(CHANNEL_COUNT);
	localparam int ENTRY_SHIFT      = 14;
	localparam int SECTOR_SHIFT     = 12;

	localparam logic [LINK_W-1:0] LINK_NIL    = '1;
	localparam logic [31:0]       NO_PAGE     = '1;
	localparam logic [6:0]        MAX_SECTORS = 7'd64;

	typedef enum logic [2:0] {
		KIND_TO_HOST    = 3'd0,
		KIND_FROM_HOST  = 3'd1,
		KIND_WRITE_BACK = 3'd2,
		KIND_FLASH_READ = 3'd3,
		KIND_PRE_READ   = 3'd4
	} kind_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] start_sector;
		logic [6:0]  sector_count;
		logic [7:0]  slot_tag;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [8:0]  buffer_entry;
		logic [29:0] page_number;
		logic [31:0] dev_addr;
		logic [7:0]  tag_out;
		logic [5:0]  dma_start_index;
		logic [2:0]  sub_sectors;
		logic [2:0]  channel;
		logic [1:0]  way;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_PAGE, ST_RD, ST_CMP, ST_MISS, ST_LINK_RD, ST_LINK,
		ST_UNP, ST_UNN, ST_WB, ST_PUSH, ST_PUSH2, ST_EMIT
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic page;
		logic cmp;
		logic miss;
		logic link;
		logic unp;
		logic unn;
		logic wb;
		logic push;
		logic push2;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic zero_cnt;
		logic head_ok;
		logic hit;
		logic next_ok;
		logic wb_need;
		logic last_page;
	} sts_t;

endpackage

@@ rtl/pdlru_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module pdlru_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/pdlru_ctrl.sv @@
// Sequencer for the per-die LRU page buffer
module pdlru_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pdlru_pkg::sts_t sts,
	output pdlru_pkg::cmd_t cmd
);
	pdlru_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdlru_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdlru_pkg::ST_CLEAR:   if (sts.clear_done) state_d = pdlru_pkg::ST_IDLE;
			pdlru_pkg::ST_IDLE:    if (start && !sts.zero_cnt) state_d = pdlru_pkg::ST_PAGE;
			pdlru_pkg::ST_PAGE:    state_d = sts.head_ok ? pdlru_pkg::ST_RD : pdlru_pkg::ST_MISS;
			pdlru_pkg::ST_RD:      state_d = pdlru_pkg::ST_CMP;
			pdlru_pkg::ST_CMP: begin
				if (sts.hit) state_d = pdlru_pkg::ST_LINK_RD;
				else if (sts.next_ok) state_d = pdlru_pkg::ST_RD;
				else state_d = pdlru_pkg::ST_MISS;
			end
			pdlru_pkg::ST_MISS:    state_d = pdlru_pkg::ST_LINK_RD;
			pdlru_pkg::ST_LINK_RD: state_d = pdlru_pkg::ST_LINK;
			pdlru_pkg::ST_LINK:    state_d = pdlru_pkg::ST_UNP;
			pdlru_pkg::ST_UNP:     state_d = pdlru_pkg::ST_UNN;
			pdlru_pkg::ST_UNN:     state_d = sts.wb_need ? pdlru_pkg::ST_WB : pdlru_pkg::ST_PUSH;
			pdlru_pkg::ST_WB:      state_d = pdlru_pkg::ST_PUSH;
			pdlru_pkg::ST_PUSH:    state_d = pdlru_pkg::ST_PUSH2;
			pdlru_pkg::ST_PUSH2:   state_d = pdlru_pkg::ST_EMIT;
			pdlru_pkg::ST_EMIT:    state_d = sts.last_page ? pdlru_pkg::ST_IDLE : pdlru_pkg::ST_PAGE;
			default:               state_d = pdlru_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		busy      = 1'b1;
		unique case (state_q)
			pdlru_pkg::ST_CLEAR:   cmd.clr = 1'b1;
			pdlru_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			pdlru_pkg::ST_PAGE:    cmd.page = 1'b1;
			pdlru_pkg::ST_RD:      ;
			pdlru_pkg::ST_CMP:     cmd.cmp = 1'b1;
			pdlru_pkg::ST_MISS:    cmd.miss = 1'b1;
			pdlru_pkg::ST_LINK_RD: ;
			pdlru_pkg::ST_LINK:    cmd.link = 1'b1;
			pdlru_pkg::ST_UNP:     cmd.unp = 1'b1;
			pdlru_pkg::ST_UNN:     cmd.unn = 1'b1;
			pdlru_pkg::ST_WB:      cmd.wb = 1'b1;
			pdlru_pkg::ST_PUSH:    cmd.push = 1'b1;
			pdlru_pkg::ST_PUSH2:   cmd.push2 = 1'b1;
			pdlru_pkg::ST_EMIT:    cmd.emit = 1'b1;
			default:               ;
		endcase
	end
endmodule

@@ rtl/pdlru_dp.sv @@
// Datapath: entry memories, per-die list ends, request tracking and result register
module pdlru_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  pdlru_pkg::cmd_t cmd,
	output pdlru_pkg::sts_t sts,
	input  pdlru_pkg::req_t request,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	output pdlru_pkg::res_t result,
	output logic            result_strobe
);
	localparam int LW = pdlru_pkg::LINK_W;
	localparam int EW = pdlru_pkg::ENT_W;
	localparam int DW = pdlru_pkg::DIE_W;
	localparam int SPP = pdlru_pkg::SECTORS_PER_PAGE;
	localparam logic [LW-1:0] TOTAL_L = LW'(pdlru_pkg::TOTAL_ENTRIES);

	logic [31:0]       base_q;
	logic              w_q;
	logic [7:0]        tag_q;
	logic [pdlru_pkg::SPP_W-1:0] off_q;
	logic [31:0]       page_q;
	logic [6:0]        rem_q;
	logic              first_q;
	logic [6:0]        dma_q;
	logic [LW-1:0]     e_q, p_q, n_q, h_q;
	logic [LW-1:0]     steps_q;
	logic              hit_q, dirty_q;
	logic [31:0]       oldpage_q;
	logic [EW-1:0]     clr_q;
	logic [LW-1:0]     head_q [pdlru_pkg::DIE_COUNT];
	logic [LW-1:0]     tail_q [pdlru_pkg::DIE_COUNT];
	pdlru_pkg::res_t   res_q;
	logic              strobe_q;

	logic [31:0]   page_rd;
	logic          dirty_rd;
	logic [LW-1:0] prev_rd, next_rd;

	logic          page_we, dirty_we, prev_we, next_we;
	logic [EW-1:0] page_wa, dirty_wa, prev_wa, next_wa;
	logic [31:0]   page_wd;
	logic          dirty_wd;
	logic [LW-1:0] prev_wd, next_wd;

	logic [DW-1:0] die;
	logic [EW-1:0] e_idx;
	logic [LW-1:0] head_cur, tail_cur;
	logic [2:0]    room, sub;
	logic [6:0]    cnt_sat;
	logic [31:0]   entry_addr;

	assign die      = page_q[DW-1:0];
	assign e_idx    = e_q[EW-1:0];
	assign head_cur = head_q[die];
	assign tail_cur = tail_q[die];
	assign room     = (rem_q > 7'(SPP)) ? 3'(SPP) : rem_q[2:0];
	assign sub      = room - (first_q ? 3'(off_q) : 3'd0);
	assign cnt_sat  = (request.sector_count > pdlru_pkg::MAX_SECTORS) ?
		pdlru_pkg::MAX_SECTORS : request.sector_count;
	assign entry_addr = base_q + (32'(e_idx) << pdlru_pkg::ENTRY_SHIFT);

	assign sts.clear_done = (clr_q == EW'(pdlru_pkg::TOTAL_ENTRIES - 1));
	assign sts.zero_cnt   = (request.sector_count == 7'd0);
	assign sts.head_ok    = (head_cur < TOTAL_L);
	assign sts.hit        = (page_rd == page_q) && (page_q != pdlru_pkg::NO_PAGE);
	assign sts.next_ok    = (next_rd < TOTAL_L) && (steps_q != LW'(pdlru_pkg::TOTAL_ENTRIES - 1));
	assign sts.wb_need    = dirty_q && !hit_q;
	assign sts.last_page  = (rem_q <= 7'(SPP));

	// memory write ports
	always_comb begin
		page_we  = 1'b0;
		page_wa  = e_idx;
		page_wd  = page_q;
		dirty_we = 1'b0;
		dirty_wa = e_idx;
		dirty_wd = w_q;
		prev_we  = 1'b0;
		prev_wa  = e_idx;
		prev_wd  = pdlru_pkg::LINK_NIL;
		next_we  = 1'b0;
		next_wa  = e_idx;
		next_wd  = pdlru_pkg::LINK_NIL;
		if (cmd.clr) begin
			page_we  = 1'b1;
			page_wa  = clr_q;
			page_wd  = pdlru_pkg::NO_PAGE;
			dirty_we = 1'b1;
			dirty_wa = clr_q;
			dirty_wd = 1'b0;
			prev_we  = 1'b1;
			prev_wa  = clr_q;
			prev_wd  = (clr_q[pdlru_pkg::EPD_W-1:0] == '0) ?
				pdlru_pkg::LINK_NIL : LW'(clr_q - EW'(1));
			next_we  = 1'b1;
			next_wa  = clr_q;
			next_wd  = (clr_q[pdlru_pkg::EPD_W-1:0] == '1) ?
				pdlru_pkg::LINK_NIL : LW'(clr_q + EW'(1));
		end
		if (cmd.unp && (p_q < TOTAL_L)) begin
			next_we = 1'b1;
			next_wa = p_q[EW-1:0];
			next_wd = n_q;
		end
		if (cmd.unn && (n_q < TOTAL_L)) begin
			prev_we = 1'b1;
			prev_wa = n_q[EW-1:0];
			prev_wd = p_q;
		end
		if (cmd.push) begin
			prev_we  = 1'b1;
			next_we  = 1'b1;
			next_wd  = (head_cur < TOTAL_L) ? head_cur : pdlru_pkg::LINK_NIL;
			page_we  = !hit_q;
			dirty_we = !hit_q || w_q;
		end
		if (cmd.push2 && (h_q < TOTAL_L)) begin
			prev_we = 1'b1;
			prev_wa = h_q[EW-1:0];
			prev_wd = e_q;
		end
	end

	pdlru_ram #(.W(32), .D(pdlru_pkg::TOTAL_ENTRIES)) u_page_ram (
		.clk(clk), .we(page_we), .waddr(page_wa), .wdata(page_wd),
		.raddr(e_idx), .rdata(page_rd)
	);
	pdlru_ram #(.W(1), .D(pdlru_pkg::TOTAL_ENTRIES)) u_dirty_ram (
		.clk(clk), .we(dirty_we), .waddr(dirty_wa), .wdata(dirty_wd),
		.raddr(e_idx), .rdata(dirty_rd)
	);
	pdlru_ram #(.W(LW), .D(pdlru_pkg::TOTAL_ENTRIES)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(e_idx), .rdata(prev_rd)
	);
	pdlru_ram #(.W(LW), .D(pdlru_pkg::TOTAL_ENTRIES)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(e_idx), .rdata(next_rd)
	);

	// control registers: list ends, clear counter, buffer base, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < pdlru_pkg::DIE_COUNT; d++) begin
				head_q[d] <= LW'(d * pdlru_pkg::ENTRIES_PER_DIE);
				tail_q[d] <= LW'(d * pdlru_pkg::ENTRIES_PER_DIE + pdlru_pkg::ENTRIES_PER_DIE - 1);
			end
			clr_q    <= '0;
			base_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) base_q <= cfg_wdata;
			if (cmd.clr) clr_q <= clr_q + EW'(1);
			if (cmd.unp && !(p_q < TOTAL_L)) head_q[die] <= n_q;
			if (cmd.unn && !(n_q < TOTAL_L)) tail_q[die] <= p_q;
			if (cmd.push) begin
				if (!(head_cur < TOTAL_L)) tail_q[die] <= e_q;
				head_q[die] <= e_q;
			end
			strobe_q <= cmd.wb || cmd.emit;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q     <= request.cmd;
			tag_q   <= request.slot_tag;
			off_q   <= request.start_sector[pdlru_pkg::SPP_W-1:0];
			page_q  <= request.start_sector >> pdlru_pkg::SPP_W;
			rem_q   <= 7'(request.start_sector[pdlru_pkg::SPP_W-1:0]) + cnt_sat;
			first_q <= 1'b1;
			dma_q   <= '0;
		end
		if (cmd.page) begin
			e_q     <= head_cur;
			steps_q <= '0;
			hit_q   <= 1'b0;
		end
		if (cmd.cmp) begin
			hit_q <= sts.hit;
			if (!sts.hit) begin
				e_q     <= next_rd;
				steps_q <= steps_q + LW'(1);
			end
		end
		if (cmd.miss) begin
			e_q <= (tail_cur < TOTAL_L) ? tail_cur :
				LW'({die, {pdlru_pkg::EPD_W{1'b0}}});
		end
		if (cmd.link) begin
			p_q       <= prev_rd;
			n_q       <= next_rd;
			dirty_q   <= dirty_rd;
			oldpage_q <= page_rd;
		end
		if (cmd.push) h_q <= head_cur;
		if (cmd.wb) begin
			res_q.kind            <= pdlru_pkg::KIND_WRITE_BACK;
			res_q.buffer_entry    <= e_idx;
			res_q.page_number     <= oldpage_q[29:0];
			res_q.dev_addr        <= entry_addr;
			res_q.tag_out         <= tag_q;
			res_q.dma_start_index <= '0;
			res_q.sub_sectors     <= 3'(SPP);
			res_q.channel         <= 3'(die[pdlru_pkg::CH_W-1:0]);
			res_q.way             <= 2'(die >> pdlru_pkg::CH_W);
			res_q.last            <= 1'b0;
		end
		if (cmd.emit) begin
			if (hit_q) begin
				res_q.kind <= w_q ? pdlru_pkg::KIND_FROM_HOST : pdlru_pkg::KIND_TO_HOST;
			end else begin
				res_q.kind <= w_q ? pdlru_pkg::KIND_PRE_READ : pdlru_pkg::KIND_FLASH_READ;
			end
			res_q.buffer_entry    <= e_idx;
			res_q.page_number     <= page_q[29:0];
			res_q.dev_addr        <= entry_addr + (first_q ?
				(32'(off_q) << pdlru_pkg::SECTOR_SHIFT) : 32'd0);
			res_q.tag_out         <= tag_q;
			res_q.dma_start_index <= dma_q[5:0];
			res_q.sub_sectors     <= sub;
			res_q.channel         <= 3'(die[pdlru_pkg::CH_W-1:0]);
			res_q.way             <= 2'(die >> pdlru_pkg::CH_W);
			res_q.last            <= sts.last_page;
			// advance to the next page of the request
			page_q  <= page_q + 32'd1;
			rem_q   <= rem_q - 7'(SPP);
			first_q <= 1'b0;
			dma_q   <= dma_q + 7'(sub);
		end
	end

	assign result        = res_q;
	assign result_strobe = strobe_q;
endmodule

@@ rtl/per_die_lru_page_buffer.sv @@
// Per-die LRU page buffer: one request at a time, a page at a time. Each page walks its die's
// list from the head over the registered-read memories; on a miss the tail entry is taken and,
// if dirty, written back. The entry is then unlinked and pushed to the head of the list.
// A page's command is strobed in the cycle after its page ends, after any write-back command.
// Busy drops with the last command, so the next request can be taken in that same cycle.
// After reset busy stays high while the entry memories are initialized.
module per_die_lru_page_buffer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pdlru_pkg::req_t request,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	output pdlru_pkg::res_t result,
	output logic            result_strobe
);
	pdlru_pkg::cmd_t cmd;
	pdlru_pkg::sts_t sts;

	pdlru_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	pdlru_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .request(request),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result(result),
		.result_strobe(result_strobe)
	);
endmodule

@@ rtl/pdlru_chk.sv @@
// Port-level checker for the per-die LRU page buffer
`include "per_die_lru_page_buffer_assert.svh"

module pdlru_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input pdlru_pkg::req_t request,
	input pdlru_pkg::res_t result,
	input logic            result_strobe
);
	`PDLRU_ASSERT_IMP(a_sub_range, clk, arst_n, result_strobe, (result.sub_sectors != 3'd0) && (result.sub_sectors <= 3'd4))
	`PDLRU_ASSERT_NXT(a_last_quiet, clk, arst_n, result_strobe && result.last, !result_strobe)
	`PDLRU_ASSERT_IMP(a_wb_pair, clk, arst_n, result_strobe && (result.kind == pdlru_pkg::KIND_WRITE_BACK), ##3 (result_strobe && (result.buffer_entry == $past(result.buffer_entry, 3)) && ((result.kind == pdlru_pkg::KIND_FLASH_READ) || (result.kind == pdlru_pkg::KIND_PRE_READ))))
	`PDLRU_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy && (request.sector_count != 7'd0), busy)
endmodule

bind per_die_lru_page_buffer pdlru_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
	.result(result), .result_strobe(result_strobe)
);

@@ sim/per_die_lru_page_buffer_test.sv @@
// Testbench for the per-die LRU page buffer: directed and random host requests checked against a cache model
module per_die_lru_page_buffer_test;
	import pdlru_pkg::*;

	localparam int SPP     = 4;
	localparam int DIES    = 32;
	localparam int EPD     = 16;
	localparam int ENTRIES = DIES * EPD;
	localparam int NULL_LINK = 'h7fff;
	localparam int WATCH_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	req_t        request = '0;
	logic        cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	res_t        result;
	logic        result_strobe;

	int errors = 0;
	int idle_cycles = 0;
	int n_results = 0;
	int n_hits = 0;
	int n_writebacks = 0;

	per_die_lru_page_buffer DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result(result),
		.result_strobe(result_strobe)
	);

	always #5 clk = ~clk;

	class cache_scoreboard;
		logic [31:0] base;
		logic [31:0] pg [ENTRIES];
		bit          dirty [ENTRIES];
		int          prv [ENTRIES];
		int          nxt [ENTRIES];
		int          head [DIES];
		int          tail [DIES];
		res_t        pending [$];

		function void clear_cache();
			base = '0;
			for (int d = 0; d < DIES; d++) begin
				for (int j = 0; j < EPD; j++) begin
					pg[d*EPD+j] = '1;
					dirty[d*EPD+j] = 0;
					prv[d*EPD+j] = (j == 0) ? NULL_LINK : d*EPD+j-1;
					nxt[d*EPD+j] = (j == EPD-1) ? NULL_LINK : d*EPD+j+1;
				end
				head[d] = d*EPD;
				tail[d] = d*EPD+EPD-1;
			end
		endfunction

		function bit ok(int e);
			return e >= 0 && e < ENTRIES;
		endfunction

		function void unlink(int d, int e);
			int p, n;
			p = prv[e];
			n = nxt[e];
			if (ok(p)) nxt[p] = n; else head[d] = n;
			if (ok(n)) prv[n] = p; else tail[d] = p;
		endfunction

		function void to_head(int d, int e);
			int h;
			h = head[d];
			prv[e] = NULL_LINK;
			if (ok(h)) begin
				nxt[e] = h;
				prv[h] = e;
			end else begin
				nxt[e] = NULL_LINK;
				tail[d] = e;
			end
			head[d] = e;
		endfunction

		function res_t make_cmd(kind_t k, int e, logic [31:0] p, logic [31:0] a,
				logic [7:0] tag, int dma, int sub, int d);
			res_t r;
			r.kind = k;
			r.buffer_entry = e[8:0];
			r.page_number = p[29:0];
			r.dev_addr = a;
			r.tag_out = tag;
			r.dma_start_index = dma[5:0];
			r.sub_sectors = sub[2:0];
			r.channel = 3'(d % 8);
			r.way = 2'(d / 8);
			r.last = 1'b0;
			return r;
		endfunction

		function void note_request(req_t q);
			int cnt, off, total, pages, dma, d, room, sub, e, steps;
			logic [31:0] page, addr;
			bit hit, any;
			kind_t k;
			cnt = q.sector_count;
			if (cnt == 0) return;
			if (cnt > 64) cnt = 64;
			off = q.start_sector % SPP;
			total = off + cnt;
			pages = (total + SPP - 1) / SPP;
			dma = 0;
			any = 0;
			for (int i = 0; i < pages; i++) begin
				page = q.start_sector / SPP + i;
				d = page % DIES;
				room = total - i*SPP;
				sub = ((room < SPP) ? room : SPP) - ((i == 0) ? off : 0);
				e = head[d];
				steps = 0;
				hit = 0;
				while (ok(e) && steps < ENTRIES) begin
					if (pg[e] == page && page != '1) begin
						hit = 1;
						break;
					end
					e = nxt[e];
					steps++;
				end
				if (hit) begin
					unlink(d, e);
					to_head(d, e);
					if (q.cmd) dirty[e] = 1;
					k = q.cmd ? KIND_FROM_HOST : KIND_TO_HOST;
				end else begin
					e = tail[d];
					if (!ok(e)) e = d*EPD;
					unlink(d, e);
					if (dirty[e])
						pending.push_back(make_cmd(KIND_WRITE_BACK, e, pg[e],
							base + e*16384, q.slot_tag, 0, SPP, d));
					dirty[e] = q.cmd;
					to_head(d, e);
					pg[e] = page;
					k = q.cmd ? KIND_PRE_READ : KIND_FLASH_READ;
				end
				addr = base + e*16384;
				if (i == 0) addr += off*4096;
				pending.push_back(make_cmd(k, e, page, addr, q.slot_tag, dma, sub, d));
				dma += sub;
			end
			pending[$].last = 1;
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected %h actual %h", $time, want, got);
				errors++;
			end
			n_results++;
			if (got.kind == KIND_TO_HOST || got.kind == KIND_FROM_HOST) n_hits++;
			if (got.kind == KIND_WRITE_BACK) n_writebacks++;
		endfunction
	endclass

	cache_scoreboard sb;

	always @(posedge clk) begin
		if (arst_n && result_strobe) sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// start stays high after an accept when the next item follows with no gap
	task automatic send_request(req_t q);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		request <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(q);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_base(logic [31:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.base = v;
		@(posedge clk);
	endtask

	function automatic req_t mk(bit w, logic [31:0] s, int c, logic [7:0] t);
		req_t q;
		q.cmd = w;
		q.start_sector = s;
		q.sector_count = 7'(c);
		q.slot_tag = t;
		return q;
	endfunction

	// keep most pages inside a small window so hits, evictions and write-backs all occur
	function automatic req_t random_request(logic [31:0] win);
		int c;
		logic [31:0] s;
		c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
		if ($urandom_range(0, 9) == 0) s = $urandom();
		else s = win + $urandom_range(0, 32*20*4);
		return mk(1'($urandom_range(0, 1)), s, c, 8'($urandom_range(0, 255)));
	endfunction

	initial begin
		logic [31:0] win;
		sb = new();
		sb.clear_cache();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request(mk(0, 32'd0, 1, 8'h00));
		send_request(mk(1, 32'd0, 1, 8'hff));
		send_request(mk(0, 32'd0, 4, 8'h11));
		send_request(mk(1, 32'd3, 64, 8'h22));
		send_request(mk(0, 32'd5, 127, 8'h33));
		send_request(mk(0, 32'd9, 0, 8'h44));
		send_request(mk(1, 32'hffffffff, 1, 8'h55));
		send_request(mk(0, 32'hfffffffc, 8, 8'h66));
		send_request(mk(1, 32'h7ffffffe, 3, 8'haa));
		for (int i = 0; i < 17; i++) send_request(mk(1'b1, 32'(i*128), 2, 8'(i)));
		drain();

		set_base(32'hffffffff);
		send_request(mk(0, 32'd6, 7, 8'h5a));
		drain();
		set_base(32'hfff00000);

		for (int ph = 0; ph < 4; ph++) begin
			win = (ph == 3) ? 32'hfffff000 : $urandom_range(0, 1000) * 4;
			for (int i = 0; i < 43; i++) send_request(random_request(win));
			drain();
			set_base($urandom());
		end
		set_base(32'h0);
		for (int i = 0; i < 30; i++) send_request(random_request(32'h0));
		drain();

		$display("Ran about 230 requests over several buffer bases: %0d commands, %0d hits, %0d write-backs",
			n_results, n_hits, n_writebacks);
		if (errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
